// File: rtl/lfcg_pkg.sv
package lfcg_pkg;

	localparam int NORM_W     = 40;
	localparam int LOG_W      = 22;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FFT_SIZE_LOG2 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INVERT        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_BOOST_DB  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_POINTS    = 3'd4;

	localparam logic [17:0]        RST_SAMPLE_RATE   = 18'd48000;
	localparam logic [4:0]         RST_FFT_SIZE_LOG2 = 5'd10;
	localparam logic signed [14:0] RST_MAX_BOOST_DB  = 15'sd1536;
	localparam logic [6:0]         RST_NUM_POINTS    = 7'd1;

	// log2(10)/20 in Q16
	localparam logic signed [15:0] DB_TO_LOG2_Q16 = 16'sd10885;
	localparam logic [37:0]        ONE_HZ_Q4      = 38'd16;

	typedef struct packed {
		logic               func;
		logic [5:0]         point_index;
		logic [20:0]        point_freq;
		logic signed [15:0] point_level;
		logic [15:0]        bin_index;
	} in_word_t;

	typedef struct packed {
		logic [31:0] gain;
		logic [15:0] bin_echo;
	} out_word_t;

	// floor(log2(1 + i/2^bits) * 2^16) by repeated squaring
	function automatic logic [16:0] log_entry(input int unsigned i, input int unsigned bits);
		logic [63:0] y;
		logic [16:0] r;
		r = '0;
		if (i >= (32'd1 << bits)) return 17'h10000;
		y = ((64'd1 << bits) + 64'(i)) << (30 - bits);
		for (int b = 0; b < 16; b++) begin
			y = (y * y) >> 30;
			r = r << 1;
			if (y >= 64'h8000_0000) begin
				r[0] = 1'b1;
				y = y >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] r;
		logic [63:0] bm;
		logic [63:0] v;
		v  = x;
		r  = '0;
		bm = 64'h4000_0000_0000_0000;
		while (bm > v) bm = bm >> 2;
		while (bm != 0) begin
			if (v >= r + bm) begin
				v = v - (r + bm);
				r = (r >> 1) + bm;
			end else begin
				r = r >> 1;
			end
			bm = bm >> 2;
		end
		return r;
	endfunction

	// 2^(i/2^bits) in Q30
	function automatic logic [31:0] exp_entry(input int unsigned i, input int unsigned bits);
		logic [63:0] acc;
		logic [63:0] c;
		acc = 64'd1 << 30;
		if (i >= (32'd1 << bits)) return 32'h8000_0000;
		c = isqrt64(64'd2 << 60);
		for (int unsigned j = 1; j <= bits; j++) begin
			if (((i >> (bits - j)) & 1) != 0) acc = (acc * c) >> 30;
			c = isqrt64(c << 30);
		end
		return acc[31:0];
	endfunction

endpackage

// File: rtl/lfcg_ram.sv
module lfcg_ram #(
	parameter int WIDTH = 37,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/lfcg_log2.sv
module lfcg_log2 #(
	parameter int LOG_TABLE_BITS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lfcg_pkg::NORM_W-1:0] operand,
	output logic                        busy,
	output logic                        done,
	output logic [lfcg_pkg::LOG_W-1:0]  result
);
	import lfcg_pkg::*;

	localparam int LB = LOG_TABLE_BITS;
	localparam int LN = 1 << LB;

	typedef enum logic [3:0] {
		L_IDLE = 4'b0001,
		L_NORM = 4'b0010,
		L_LOOK = 4'b0100,
		L_SUM  = 4'b1000
	} lstate_t;

	lstate_t            state_q;
	logic [NORM_W-1:0]  v_q;
	logic [5:0]         e_q;
	logic [32:0]        prod_s1;
	logic [LOG_W-1:0]   base_s1;
	logic               done_q;
	logic [LOG_W-1:0]   result_q;

	logic [16:0]        log_tab [0:LN];
	logic [LB:0]        ia;
	logic [LB:0]        ib;
	logic [15:0]        rem;
	logic [16:0]        diff;

	for (genvar g = 0; g <= LN; g++) begin : g_tab
		assign log_tab[g] = log_entry(g, LB);
	end

	// mantissa below the leading one sits in v_q[NORM_W-2:0]
	assign ia   = {1'b0, v_q[NORM_W-2 -: LB]};
	assign ib   = ia + (LB+1)'(1);
	assign rem  = v_q[NORM_W-2-LB -: 16];
	assign diff = log_tab[ib] - log_tab[ia];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				L_IDLE: if (start) state_q <= L_NORM;
				L_NORM: if (v_q[NORM_W-1]) state_q <= L_LOOK;
				L_LOOK: state_q <= L_SUM;
				L_SUM: begin
					state_q <= L_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			L_IDLE: begin
				if (start) begin
					v_q <= (operand == '0) ? NORM_W'(1) : operand;
					e_q <= 6'(NORM_W - 1);
				end
			end
			L_NORM: begin
				if (!v_q[NORM_W-1]) begin
					if (v_q[NORM_W-1 -: 8] == '0) begin
						v_q <= v_q << 8;
						e_q <= e_q - 6'd8;
					end else begin
						v_q <= v_q << 1;
						e_q <= e_q - 6'd1;
					end
				end
			end
			L_LOOK: begin
				prod_s1 <= 33'(diff) * 33'(rem);
				base_s1 <= {e_q, 16'd0} + LOG_W'(log_tab[ia]);
			end
			L_SUM: result_q <= base_s1 + LOG_W'(prod_s1[32:16]);
			default: ;
		endcase
	end

	assign busy   = (state_q != L_IDLE);
	assign done   = done_q;
	assign result = result_q;
endmodule

// File: rtl/lfcg_div.sv
module lfcg_div #(
	parameter int ND = 38,
	parameter int DD = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [ND-1:0] dividend,
	input  logic [DD-1:0] divisor,
	output logic          done,
	output logic [ND-1:0] quotient
);
	localparam int CW = $clog2(ND + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DD-1:0] rem_q;
	logic [ND-1:0] quo_q;
	logic [DD-1:0] div_q;
	logic [DD:0]   sh;
	logic          ge;

	assign sh = {rem_q, quo_q[ND-1]};
	assign ge = (sh >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(ND);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	// restoring, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? DD'(sh - {1'b0, div_q}) : sh[DD-1:0];
			quo_q <= {quo_q[ND-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;
endmodule

// File: rtl/log_freq_cal_curve_gain_core.sv
// A point write goes into the point table while idle; a bin query goes straight to dB to gain
//   at or beyond a table end, else through a binary search, three log2 passes (lo point, hi
//   point, bin frequency), the 38-step divider when the log span is positive, and dB to gain.
// Throughput: one query at a time; the next word is taken once the result is registered.
// Reset: arst_n asynchronous, active low; clears the sequencer and output valid and sets the
//   configuration registers to their defaults. The point table is not cleared.
module log_freq_cal_curve_gain_core #(
	parameter int MAX_POINTS     = 64,
	parameter int LOG_TABLE_BITS = 8,
	parameter int EXP_TABLE_BITS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lfcg_pkg::in_word_t              in_word,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lfcg_pkg::out_word_t             out_word,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfcg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lfcg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lfcg_pkg::*;

	localparam int AW  = $clog2(MAX_POINTS);
	localparam int EB  = EXP_TABLE_BITS;
	localparam int ER  = 16 - EB;
	localparam int EN  = 1 << EB;
	localparam int DVN = 38;
	localparam int DVD = LOG_W;

	typedef enum logic [16:0] {
		ST_IDLE  = 17'b00000000000000001,
		ST_MUL   = 17'b00000000000000010,
		ST_SHIFT = 17'b00000000000000100,
		ST_CHK0  = 17'b00000000000001000,
		ST_CHKN  = 17'b00000000000010000,
		ST_SRCH  = 17'b00000000000100000,
		ST_SCMP  = 17'b00000000001000000,
		ST_LOG   = 17'b00000000010000000,
		ST_LOGW  = 17'b00000000100000000,
		ST_DEN   = 17'b00000001000000000,
		ST_PROD  = 17'b00000010000000000,
		ST_DIVS  = 17'b00000100000000000,
		ST_DIVW  = 17'b00001000000000000,
		ST_DB    = 17'b00010000000000000,
		ST_EXP1  = 17'b00100000000000000,
		ST_EXP2  = 17'b01000000000000000,
		ST_EXP3  = 17'b10000000000000000
	} state_t;

	// configuration
	logic [17:0]        sample_rate_q;
	logic [4:0]         fft_size_log2_q;
	logic               invert_q;
	logic signed [14:0] max_boost_q;
	logic [6:0]         num_points_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q   <= RST_SAMPLE_RATE;
			fft_size_log2_q <= RST_FFT_SIZE_LOG2;
			invert_q        <= 1'b0;
			max_boost_q     <= RST_MAX_BOOST_DB;
			num_points_q    <= RST_NUM_POINTS;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SAMPLE_RATE:   sample_rate_q   <= cfg_data[17:0];
				CFG_FFT_SIZE_LOG2: fft_size_log2_q <= cfg_data[4:0];
				CFG_INVERT:        invert_q        <= cfg_data[0];
				CFG_MAX_BOOST_DB:  max_boost_q     <= $signed(cfg_data[14:0]);
				CFG_NUM_POINTS:    num_points_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// sequencer and datapath registers
	state_t             state_q;
	logic [1:0]         cnt_q;
	logic               out_valid_q;
	out_word_t          out_word_q;
	logic [15:0]        bin_q;
	logic [33:0]        prod_q;
	logic [37:0]        x_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic [20:0]        flo_q;
	logic [20:0]        fhi_q;
	logic signed [15:0] llo_q;
	logic signed [15:0] lhi_q;
	logic [LOG_W-1:0]   ll_q;
	logic [LOG_W-1:0]   lh_q;
	logic [LOG_W-1:0]   lx_q;
	logic [LOG_W-1:0]   num_q;
	logic [LOG_W-1:0]   den_q;
	logic signed [16:0] diff_q;
	logic signed [39:0] mul_q;
	logic               neg_q;
	logic signed [15:0] lev_q;
	logic signed [17:0] db_q;
	logic signed [25:0] p_q;
	logic signed [9:0]  ip_q;
	logic [31:0]        m_q;

	// point table: freq in the upper bits, level below
	logic               ram_we;
	logic [AW-1:0]      ram_raddr;
	logic [36:0]        ram_rdata;
	logic [20:0]        rd_freq;
	logic signed [15:0] rd_level;
	logic [31:0]        pidx32;

	assign pidx32   = 32'(in_word.point_index);
	assign ram_we   = in_valid && in_ready && !in_word.func && (pidx32 < 32'(MAX_POINTS));
	assign rd_freq  = ram_rdata[36:16];
	assign rd_level = $signed(ram_rdata[15:0]);

	lfcg_ram #(.WIDTH(37), .DEPTH(MAX_POINTS)) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(AW'(pidx32)),
		.wdata({in_word.point_freq, in_word.point_level}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// last valid slot, with the point count held to 1..MAX_POINTS
	logic [31:0]   np32;
	logic [AW-1:0] nm1;
	logic [AW-1:0] mid;

	assign np32 = 32'(num_points_q);
	assign nm1  = (np32 == 32'd0) ? '0 :
	              (np32 > 32'(MAX_POINTS)) ? AW'(MAX_POINTS - 1) : AW'(np32 - 32'd1);
	assign mid  = AW'(((AW+1)'(lo_q) + (AW+1)'(hi_q)) >> 1);

	always_comb begin
		case (state_q)
			ST_SHIFT: ram_raddr = '0;
			ST_CHK0:  ram_raddr = nm1;
			default:  ram_raddr = mid;
		endcase
	end

	// shared log2 unit: lo point, hi point, then the bin frequency
	logic              log_start;
	logic              log_busy;
	logic              log_done;
	logic [LOG_W-1:0]  log_res;
	logic [NORM_W-1:0] log_opnd;

	assign log_start = (state_q == ST_LOG);

	always_comb begin
		case (cnt_q)
			2'd0:    log_opnd = NORM_W'(flo_q);
			2'd1:    log_opnd = NORM_W'(fhi_q);
			default: log_opnd = NORM_W'(x_q);
		endcase
	end

	lfcg_log2 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log2 (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.operand(log_opnd),
		.busy   (log_busy),
		.done   (log_done),
		.result (log_res)
	);

	// divider for the interpolation fraction
	logic              div_start;
	logic              div_done;
	logic [DVN-1:0]    div_quo;
	logic signed [39:0] mag;

	assign div_start = (state_q == ST_DIVS);
	assign mag       = mul_q[39] ? -mul_q : mul_q;

	lfcg_div #(.ND(DVN), .DD(DVD)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag[DVN-1:0]),
		.divisor (den_q),
		.done    (div_done),
		.quotient(div_quo)
	);

	// combinational helpers
	logic [37:0]        hz_w;
	logic signed [22:0] den_w;
	logic signed [22:0] num_w;
	logic signed [17:0] q_w;
	logic signed [17:0] lev_w;
	logic signed [17:0] db_w;
	logic signed [17:0] maxb_w;
	logic signed [33:0] pfull;

	assign hz_w   = {prod_q, 4'd0} >> fft_size_log2_q;
	assign den_w  = $signed({1'b0, lh_q}) - $signed({1'b0, ll_q});
	assign num_w  = $signed({1'b0, lx_q}) - $signed({1'b0, ll_q});
	assign q_w    = $signed({1'b0, div_quo[16:0]});
	assign lev_w  = 18'(llo_q) + (neg_q ? -q_w : q_w);
	assign db_w   = invert_q ? -18'(lev_q) : 18'(lev_q);
	assign maxb_w = 18'(max_boost_q);
	assign pfull  = 34'(db_q) * 34'(DB_TO_LOG2_Q16);

	// 2^frac table and interpolation
	logic [31:0]        exp_tab [0:EN];
	logic [EB:0]        eia;
	logic [EB:0]        eib;
	logic [ER-1:0]      erem;
	logic [31:0]        ediff;
	logic [47:0]        emul;
	logic [31:0]        m_w;

	for (genvar g = 0; g <= EN; g++) begin : g_exp
		assign exp_tab[g] = exp_entry(g, EB);
	end

	assign eia   = {1'b0, p_q[15 -: EB]};
	assign eib   = eia + (EB+1)'(1);
	assign erem  = p_q[ER-1:0];
	assign ediff = exp_tab[eib] - exp_tab[eia];
	assign emul  = (48'(ediff) * 48'(erem)) >> ER;
	assign m_w   = exp_tab[eia] + emul[31:0];

	// exponent shift to Q22 with saturation
	logic signed [10:0] sh_w;
	logic [10:0]        nsh_w;
	logic [32:0]        g1_w;
	logic [31:0]        gain_w;

	assign sh_w  = 11'(ip_q) - 11'sd8;
	assign nsh_w = 11'(-sh_w);
	assign g1_w  = {m_q, 1'b0};

	always_comb begin
		if (sh_w >= 11'sd2) begin
			gain_w = 32'hFFFF_FFFF;
		end else if (sh_w == 11'sd1) begin
			gain_w = g1_w[32] ? 32'hFFFF_FFFF : g1_w[31:0];
		end else if (sh_w == 11'sd0) begin
			gain_w = m_q;
		end else if (nsh_w >= 11'd32) begin
			gain_w = '0;
		end else begin
			gain_w = m_q >> nsh_w[4:0];
		end
	end

	logic out_load;
	assign out_load = (state_q == ST_EXP3) && (!out_valid_q || out_ready);

	// next state
	state_t state_d;
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && in_word.func) state_d = ST_MUL;
			ST_MUL:   state_d = ST_SHIFT;
			ST_SHIFT: state_d = ST_CHK0;
			ST_CHK0:  state_d = (x_q <= 38'(rd_freq)) ? ST_DB : ST_CHKN;
			ST_CHKN:  state_d = (x_q >= 38'(rd_freq)) ? ST_DB : ST_SRCH;
			ST_SRCH:  state_d = ((hi_q - lo_q) > AW'(1)) ? ST_SCMP : ST_LOG;
			ST_SCMP:  state_d = ST_SRCH;
			ST_LOG:   state_d = ST_LOGW;
			ST_LOGW:  if (log_done) state_d = (cnt_q == 2'd2) ? ST_DEN : ST_LOG;
			ST_DEN:   state_d = (den_w <= 23'sd0) ? ST_DB : ST_PROD;
			ST_PROD:  state_d = ST_DIVS;
			ST_DIVS:  state_d = ST_DIVW;
			ST_DIVW:  if (div_done) state_d = ST_DB;
			ST_DB:    state_d = ST_EXP1;
			ST_EXP1:  state_d = ST_EXP2;
			ST_EXP2:  state_d = ST_EXP3;
			ST_EXP3:  if (out_load) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SRCH) cnt_q <= '0;
			else if (state_q == ST_LOGW && log_done) cnt_q <= cnt_q + 2'd1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:  bin_q <= in_word.bin_index;
			ST_MUL:   prod_q <= 34'(bin_q) * 34'(sample_rate_q);
			ST_SHIFT: x_q <= (hz_w < ONE_HZ_Q4) ? ONE_HZ_Q4 : hz_w;
			ST_CHK0: begin
				lo_q  <= '0;
				flo_q <= rd_freq;
				llo_q <= rd_level;
				lev_q <= rd_level;
			end
			ST_CHKN: begin
				hi_q  <= nm1;
				fhi_q <= rd_freq;
				lhi_q <= rd_level;
				if (x_q >= 38'(rd_freq)) lev_q <= rd_level;
			end
			ST_SCMP: begin
				if (38'(rd_freq) <= x_q) begin
					lo_q  <= mid;
					flo_q <= rd_freq;
					llo_q <= rd_level;
				end else begin
					hi_q  <= mid;
					fhi_q <= rd_freq;
					lhi_q <= rd_level;
				end
			end
			ST_LOGW: begin
				if (log_done) begin
					case (cnt_q)
						2'd0:    ll_q <= log_res;
						2'd1:    lh_q <= log_res;
						default: lx_q <= log_res;
					endcase
				end
			end
			ST_DEN: begin
				den_q  <= den_w[LOG_W-1:0];
				diff_q <= 17'(lhi_q) - 17'(llo_q);
				lev_q  <= llo_q;
				if (num_w < 23'sd0) num_q <= '0;
				else if (num_w > den_w) num_q <= den_w[LOG_W-1:0];
				else num_q <= num_w[LOG_W-1:0];
			end
			ST_PROD:  mul_q <= 40'($signed({1'b0, num_q})) * 40'(diff_q);
			ST_DIVS:  neg_q <= mul_q[39];
			ST_DIVW:  if (div_done) lev_q <= lev_w[15:0];
			ST_DB:    db_q <= (db_w > maxb_w) ? maxb_w : db_w;
			ST_EXP1:  p_q <= 26'(pfull >>> 8);
			ST_EXP2: begin
				m_q  <= m_w;
				ip_q <= p_q[25:16];
			end
			ST_EXP3: begin
				if (out_load) begin
					out_word_q.gain     <= gain_w;
					out_word_q.bin_echo <= bin_q;
				end
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// search window never collapses while a step is pending
	a_srch_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q < hi_q))
		else $error("search window empty");

	// num is held to [0, den], so the fraction never exceeds the level step
	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVW && div_done) |-> (div_quo[DVN-1:17] == '0))
		else $error("interpolation quotient out of range");

	a_log_free: assert property (@(posedge clk) disable iff (!arst_n)
		log_start |-> !log_busy)
		else $error("log2 unit started while busy");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_EXP3))
		else $error("result raised outside the final step");
endmodule
